/* rtl/rmms_pkg.sv */
// ----------------------------------------------------------------------------
// rmms_pkg
// Shared types and constants for the region-of-interest min/max/mean block.
// ----------------------------------------------------------------------------
package rmms_pkg;

  // Field widths
  localparam int SAMPLE_W = 16;
  localparam int COUNT_W  = 21;
  localparam int SUM_W    = 37;
  localparam int CFG_W    = 13;
  localparam int CFG_IDX_W = 3;
  localparam int IMG_W    = 12;
  localparam int GRID_REG_W = 11;
  localparam int OUT_DATA_W = 72;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_A_X   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_A_Y   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_B_X   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_B_Y   = 3'd7;

  // Frame queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = 1;

  // Window unit status towards the front end
  typedef struct packed {
    logic ready;
    logic region_valid;
  } win_stat_t;

  // One finished frame as handed from front to back
  typedef struct packed {
    logic                region_valid;
    logic [SAMPLE_W-1:0] min_sample;
    logic [SAMPLE_W-1:0] max_sample;
    logic [SUM_W-1:0]    sum;
    logic [COUNT_W-1:0]  count;
  } frame_rec_t;

endpackage

/* rtl/rmms_window.sv */
// ----------------------------------------------------------------------------
// rmms_window
// Configuration registers and the window unit: clips the rectangle and scales
// each edge to a grid cell with a shared bit-serial divider.
// ----------------------------------------------------------------------------
module rmms_window import rmms_pkg::*; #(
  parameter int MAX_GRID_DIM = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [CFG_IDX_W-1:0]             cfg_index,
  input  logic [CFG_W-1:0]                 cfg_data,
  output win_stat_t                        stat,
  output logic [$clog2(MAX_GRID_DIM)-1:0]  x_lo,
  output logic [$clog2(MAX_GRID_DIM)-1:0]  x_hi,
  output logic [$clog2(MAX_GRID_DIM)-1:0]  y_lo,
  output logic [$clog2(MAX_GRID_DIM)-1:0]  y_hi,
  output logic [$clog2(MAX_GRID_DIM)-1:0]  gw_m1,
  output logic [$clog2(MAX_GRID_DIM)-1:0]  gh_m1
);

  localparam int PW  = $clog2(MAX_GRID_DIM);
  localparam int GW  = PW + 1;
  localparam int NW  = IMG_W + GW;
  localparam int CNW = $clog2(NW);

  localparam logic [1:0] W_IDLE  = 2'd0;
  localparam logic [1:0] W_LOAD  = 2'd1;
  localparam logic [1:0] W_DIV   = 2'd2;
  localparam logic [1:0] W_STORE = 2'd3;

  localparam logic [CFG_W-1:0] MAX_EXT = CFG_W'(MAX_GRID_DIM);

  logic [IMG_W-1:0]      image_width, image_height;
  logic [GRID_REG_W-1:0] grid_width, grid_height;
  logic [CFG_W-1:0]      corner_a_x, corner_a_y, corner_b_x, corner_b_y;

  logic [1:0]     state;
  logic [1:0]     job;
  logic [CNW-1:0] step;
  logic [IMG_W-1:0] rem;
  logic [NW-1:0]    dq;

  logic [GW-1:0]  gw_sat, gh_sat, grid;
  logic [PW-1:0]  grid_m1;
  logic [2*IMG_W:0] x_clip, y_clip;
  logic [IMG_W-1:0] operand, divisor;
  logic [NW-1:0]    prod;
  logic [IMG_W:0]   trial;
  logic             trial_ge;
  logic [IMG_W-1:0] rem_next;
  logic [PW-1:0]    quot_clamped;

  // Saturate a grid dimension to 1 .. MAX_GRID_DIM
  function automatic logic [GW-1:0] grid_sat(input logic [GRID_REG_W-1:0] g);
    logic [CFG_W-1:0] g_ext;
    g_ext = {{(CFG_W-GRID_REG_W){1'b0}}, g};
    if (g_ext == '0) return GW'(1);
    if (g_ext > MAX_EXT) return GW'(MAX_GRID_DIM);
    return GW'(g_ext);
  endfunction

  // Normalise and clip one axis: {non-empty, low edge, high edge}
  function automatic logic [2*IMG_W:0] axis_clip(input logic [CFG_W-1:0] ca,
                                                 input logic [CFG_W-1:0] cb,
                                                 input logic [IMG_W-1:0] img);
    logic signed [CFG_W:0] a, b, l, r, im;
    a  = {ca[CFG_W-1], ca};
    b  = {cb[CFG_W-1], cb};
    im = {2'b00, img};
    l  = (a < b) ? a : b;
    r  = (a < b) ? b : a;
    if (l < 14'sd0) l = 14'sd0;
    if (r > im) r = im;
    return {(r > l), l[IMG_W-1:0], r[IMG_W-1:0]};
  endfunction

  assign gw_sat = grid_sat(grid_width);
  assign gh_sat = grid_sat(grid_height);
  assign gw_m1  = PW'(gw_sat - GW'(1));
  assign gh_m1  = PW'(gh_sat - GW'(1));
  assign x_clip = axis_clip(corner_a_x, corner_b_x, image_width);
  assign y_clip = axis_clip(corner_a_y, corner_b_y, image_height);

  assign stat.ready        = (state == W_IDLE);
  assign stat.region_valid = (image_width != '0) && (image_height != '0) &&
                             x_clip[2*IMG_W] && y_clip[2*IMG_W];

  // Select the edge, image size and grid size for the current job
  always_comb begin
    case (job)
      2'd0:    operand = x_clip[2*IMG_W-1:IMG_W];
      2'd1:    operand = x_clip[IMG_W-1:0];
      2'd2:    operand = y_clip[2*IMG_W-1:IMG_W];
      default: operand = y_clip[IMG_W-1:0];
    endcase
    divisor = job[1] ? image_height : image_width;
    grid    = job[1] ? gh_sat : gw_sat;
    grid_m1 = job[1] ? gh_m1 : gw_m1;
  end

  assign prod = {{GW{1'b0}}, operand} * {{IMG_W{1'b0}}, grid};

  // One restoring division step per cycle
  assign trial    = {rem, dq[NW-1]};
  assign trial_ge = (trial >= {1'b0, divisor});
  assign rem_next = trial_ge ? IMG_W'(trial - {1'b0, divisor}) : trial[IMG_W-1:0];
  assign quot_clamped = (dq > {{(NW-PW){1'b0}}, grid_m1}) ? grid_m1 : dq[PW-1:0];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IMG_W'(640);
      image_height <= IMG_W'(512);
      grid_width   <= GRID_REG_W'(256);
      grid_height  <= GRID_REG_W'(192);
      corner_a_x   <= '0;
      corner_a_y   <= '0;
      corner_b_x   <= '0;
      corner_b_y   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[IMG_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[IMG_W-1:0];
        REG_GRID_WIDTH:   grid_width   <= cfg_data[GRID_REG_W-1:0];
        REG_GRID_HEIGHT:  grid_height  <= cfg_data[GRID_REG_W-1:0];
        REG_CORNER_A_X:   corner_a_x   <= cfg_data;
        REG_CORNER_A_Y:   corner_a_y   <= cfg_data;
        REG_CORNER_B_X:   corner_b_x   <= cfg_data;
        REG_CORNER_B_Y:   corner_b_y   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer: recompute the edges x_lo, x_hi, y_lo and y_hi after reset and after every write
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= W_LOAD;
      job   <= 2'd0;
    end else if (cfg_we) begin
      state <= W_LOAD;
      job   <= 2'd0;
    end else begin
      case (state)
        W_LOAD:  state <= W_DIV;
        W_DIV:   if (step == '0) state <= W_STORE;
        W_STORE: begin
          job   <= job + 2'd1;
          state <= (job == 2'd3) ? W_IDLE : W_LOAD;
        end
        default: state <= W_IDLE;
      endcase
    end
  end

  // Divider datapath and edge registers
  always_ff @(posedge clk) begin
    case (state)
      W_LOAD: begin
        dq   <= prod;
        rem  <= '0;
        step <= CNW'(NW - 1);
      end
      W_DIV: begin
        dq   <= {dq[NW-2:0], trial_ge};
        rem  <= rem_next;
        step <= step - CNW'(1);
      end
      W_STORE: begin
        case (job)
          2'd0:    x_lo <= quot_clamped;
          2'd1:    x_hi <= quot_clamped;
          2'd2:    y_lo <= quot_clamped;
          default: y_hi <= quot_clamped;
        endcase
      end
      default: ;
    endcase
  end

endmodule

/* rtl/rmms_front.sv */
// ----------------------------------------------------------------------------
// rmms_front
// Front end: takes sample beats, tracks the raster position, tests the window
// and keeps the running min, max, sum and count; queues a record per frame.
// ----------------------------------------------------------------------------
module rmms_front import rmms_pkg::*; #(
  parameter int MAX_GRID_DIM = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [SAMPLE_W-1:0]              sample,
  input  logic                             frame_last,
  input  win_stat_t                        stat,
  input  logic [$clog2(MAX_GRID_DIM)-1:0]  x_lo,
  input  logic [$clog2(MAX_GRID_DIM)-1:0]  x_hi,
  input  logic [$clog2(MAX_GRID_DIM)-1:0]  y_lo,
  input  logic [$clog2(MAX_GRID_DIM)-1:0]  y_hi,
  input  logic [$clog2(MAX_GRID_DIM)-1:0]  gw_m1,
  input  logic [$clog2(MAX_GRID_DIM)-1:0]  gh_m1,
  input  logic                             q_full,
  output logic                             q_push,
  output frame_rec_t                       q_rec
);

  localparam int PW = $clog2(MAX_GRID_DIM);

  logic [PW-1:0]       column_position, row_position;
  logic [SAMPLE_W-1:0] running_min, running_max;
  logic [SUM_W-1:0]    running_sum;
  logic [COUNT_W-1:0]  running_count;

  logic [SAMPLE_W-1:0] min_next, max_next;
  logic [SUM_W-1:0]    sum_next;
  logic [COUNT_W-1:0]  count_next;
  logic                accept, in_window, keep;

  assign in_ready = stat.ready && !q_full;
  assign accept   = in_valid && in_ready;
  assign in_window = stat.region_valid &&
                     (column_position >= x_lo) && (column_position <= x_hi) &&
                     (row_position >= y_lo) && (row_position <= y_hi);

  // Fold the current sample into the running statistics
  always_comb begin
    min_next   = running_min;
    max_next   = running_max;
    sum_next   = running_sum;
    count_next = running_count;
    if (in_window) begin
      if (sample < running_min) min_next = sample;
      if (sample > running_max) max_next = sample;
      if (running_count != COUNT_MAX) begin
        sum_next   = running_sum + {{(SUM_W-SAMPLE_W){1'b0}}, sample};
        count_next = running_count + COUNT_W'(1);
      end
    end
  end

  // Frame record: statistics only when the window held any samples
  assign keep   = stat.region_valid && (count_next != '0);
  assign q_push = accept && frame_last;
  assign q_rec.region_valid = stat.region_valid;
  assign q_rec.min_sample   = keep ? min_next : '0;
  assign q_rec.max_sample   = keep ? max_next : '0;
  assign q_rec.sum          = keep ? sum_next : '0;
  assign q_rec.count        = keep ? count_next : '0;

  // Advance the raster position and accumulators; restart on frame end
  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
      row_position    <= '0;
      running_min     <= '1;
      running_max     <= '0;
      running_sum     <= '0;
      running_count   <= '0;
    end else if (accept) begin
      if (frame_last) begin
        column_position <= '0;
        row_position    <= '0;
        running_min     <= '1;
        running_max     <= '0;
        running_sum     <= '0;
        running_count   <= '0;
      end else begin
        running_min   <= min_next;
        running_max   <= max_next;
        running_sum   <= sum_next;
        running_count <= count_next;
        if (column_position >= gw_m1) begin
          column_position <= '0;
          row_position    <= (row_position >= gh_m1) ? '0 : row_position + PW'(1);
        end else begin
          column_position <= column_position + PW'(1);
        end
      end
    end
  end

endmodule

/* rtl/rmms_queue.sv */
// ----------------------------------------------------------------------------
// rmms_queue
// Short queue of finished frame records between front and back end.
// ----------------------------------------------------------------------------
module rmms_queue import rmms_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  frame_rec_t wr_rec,
  input  logic       pop,
  output frame_rec_t rd_rec,
  output logic       not_empty,
  output logic       full
);

  frame_rec_t        entries [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr, rd_ptr;
  logic [Q_AW:0]     fill;

  assign not_empty = (fill != '0);
  assign full      = (fill == (Q_AW+1)'(Q_DEPTH));
  assign rd_rec    = entries[rd_ptr];

  // Store pushed records
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= wr_rec;
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + Q_AW'(1);
      if (pop)  rd_ptr <= rd_ptr + Q_AW'(1);
      case ({push, pop})
        2'b10:   fill <= fill + (Q_AW+1)'(1);
        2'b01:   fill <= fill - (Q_AW+1)'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

/* rtl/rmms_back.sv */
// ----------------------------------------------------------------------------
// rmms_back
// Back end: divides the frame sum by its count one quotient bit per cycle and
// holds the result in an output register until the sink takes the beat.
// ----------------------------------------------------------------------------
module rmms_back import rmms_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  frame_rec_t            q_rec,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_region_valid,
  output logic [OUT_DATA_W-1:0] out_data
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_DIV  = 2'd1;
  localparam logic [1:0] B_HOLD = 2'd2;

  localparam int QW  = SAMPLE_W;
  localparam int CNW = $clog2(QW);

  logic [1:0]         state;
  frame_rec_t         rec;
  logic [CNW-1:0]     step;
  logic [COUNT_W-1:0] rem;
  logic [QW-1:0]      dq;

  logic [COUNT_W:0]   trial;
  logic               trial_ge;
  logic [COUNT_W-1:0] rem_next;
  logic               load_out;
  logic [QW-1:0]      mean;

  assign q_pop    = (state == B_IDLE) && q_valid;
  assign load_out = (state == B_HOLD) && (!out_valid || out_ready);

  // Restoring division step; quotient fits the sample width since mean <= max
  assign trial    = {rem, dq[QW-1]};
  assign trial_ge = (trial >= {1'b0, rec.count});
  assign rem_next = trial_ge ? COUNT_W'(trial - {1'b0, rec.count}) : trial[COUNT_W-1:0];
  assign mean     = (rec.count == '0) ? '0 : dq;

  // Control: fetch, divide, hand over
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        B_IDLE: if (q_valid) state <= B_DIV;
        B_DIV:  if (step == '0) state <= B_HOLD;
        B_HOLD: if (load_out) state <= B_IDLE;
        default: state <= B_IDLE;
      endcase
      if (load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Divider datapath and output register
  always_ff @(posedge clk) begin
    if (q_pop) begin
      rec  <= q_rec;
      rem  <= q_rec.sum[SUM_W-1:QW];
      dq   <= q_rec.sum[QW-1:0];
      step <= CNW'(QW - 1);
    end else if (state == B_DIV) begin
      rem  <= rem_next;
      dq   <= {dq[QW-2:0], trial_ge};
      step <= step - CNW'(1);
    end
    if (load_out) begin
      out_region_valid <= rec.region_valid;
      out_data <= {{(OUT_DATA_W-COUNT_W-3*SAMPLE_W){1'b0}}, rec.count, mean,
                   rec.max_sample, rec.min_sample};
    end
  end

endmodule

/* rtl/roi_min_max_mean_stats.sv */
// ----------------------------------------------------------------------------
// roi_min_max_mean_stats
// Region-of-interest min, max and mean over a raster stream of thermal samples.
// ----------------------------------------------------------------------------
// Samples enter one per clock on the slave stream whenever the window is
// settled and the two-entry frame queue has room. After reset and after every
// configuration write the window unit recomputes the four grid edges with a
// shared restoring divider, one bit per cycle; s_tready stays low until the
// edges are done. Each frame end produces one result beat from the 16-step
// mean divider in the back end; the queue lets the front end carry on with
// the next frame meanwhile, so the back end holds the front end back only
// while the queue is full.
module roi_min_max_mean_stats import rmms_pkg::*; #(
  parameter int MAX_GRID_DIM = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [SAMPLE_W-1:0]   s_tdata,   // raw_sample
  input  logic                  s_tlast,   // frame_end
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // min_sample [15:0], max_sample [31:16], mean_sample [47:32],
  // cell_count [68:48], zero [71:69]
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tuser    // region_valid
);

  localparam int PW = $clog2(MAX_GRID_DIM);

  win_stat_t  win_stat;
  logic [PW-1:0] x_lo, x_hi, y_lo, y_hi, gw_m1, gh_m1;
  logic       q_push, q_pop, q_valid, q_full;
  frame_rec_t q_wr_rec, q_rd_rec;

  rmms_window #(.MAX_GRID_DIM(MAX_GRID_DIM)) u_window (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stat      (win_stat),
    .x_lo      (x_lo),
    .x_hi      (x_hi),
    .y_lo      (y_lo),
    .y_hi      (y_hi),
    .gw_m1     (gw_m1),
    .gh_m1     (gh_m1)
  );

  rmms_front #(.MAX_GRID_DIM(MAX_GRID_DIM)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .sample     (s_tdata),
    .frame_last (s_tlast),
    .stat       (win_stat),
    .x_lo       (x_lo),
    .x_hi       (x_hi),
    .y_lo       (y_lo),
    .y_hi       (y_hi),
    .gw_m1      (gw_m1),
    .gh_m1      (gh_m1),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_rec      (q_wr_rec)
  );

  rmms_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wr_rec    (q_wr_rec),
    .pop       (q_pop),
    .rd_rec    (q_rd_rec),
    .not_empty (q_valid),
    .full      (q_full)
  );

  rmms_back u_back (
    .clk              (clk),
    .rst              (rst),
    .q_valid          (q_valid),
    .q_rec            (q_rd_rec),
    .q_pop            (q_pop),
    .out_valid        (m_tvalid),
    .out_ready        (m_tready),
    .out_region_valid (m_tuser),
    .out_data         (m_tdata)
  );

  // An empty region reports all statistics as zero
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("empty region beat carries non-zero statistics");

  // The mean lies between min and max whenever anything was counted
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[68:48] != '0 |->
      m_tdata[15:0] <= m_tdata[47:32] && m_tdata[47:32] <= m_tdata[31:16])
    else $error("mean outside min/max range");

  // A configuration write holds off samples while the window is recomputed
  assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !s_tready)
    else $error("sample accepted before window recomputation");

  // No frame record is dropped: a push never meets a full queue
  assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("frame record pushed into full queue");

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for roi_min_max_mean_stats. A short directed sequence
// covers the empty region, a window that is never reached, reversed and
// out-of-image corners, a mid-frame register change, zero image size and
// saturated grid sizes. Random phases follow with random registers and
// frames that mostly match the grid. The bench predicts every result beat
// from the accepted sample beats and checks each one field by field.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rmms_pkg::*;

  localparam int GRID_LIMIT   = 1024;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASES       = 16;
  localparam int PHASE_ITEMS  = 105;
  localparam int PRESSURE_PHASE = 12;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } sample_beat_t;

  typedef struct packed {
    logic                region_valid;
    logic [SAMPLE_W-1:0] min_sample;
    logic [SAMPLE_W-1:0] max_sample;
    logic [SAMPLE_W-1:0] mean_sample;
    logic [COUNT_W-1:0]  cell_count;
  } roi_result_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [SAMPLE_W-1:0]   s_tdata;   // raw_sample
  logic                  s_tlast;   // frame_end
  logic                  m_tvalid;
  logic                  m_tready;
  // min_sample [15:0], max_sample [31:16], mean_sample [47:32],
  // cell_count [68:48], zero [71:69]
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;   // region_valid

  roi_min_max_mean_stats #(
    .MAX_GRID_DIM(GRID_LIMIT)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Stimulus and expectation stores
  sample_beat_t sample_queue[$];
  roi_result_t  frame_stats_due[$];
  int           fail_count;
  int           send_idle_pct;
  int           recv_idle_pct;
  int           holds_asked;
  int           holds_served;
  int           hold_left;

  // Shadow copy of the registers
  logic [IMG_W-1:0]      img_w, img_h;
  logic [GRID_REG_W-1:0] grid_w, grid_h;
  logic [CFG_W-1:0]      ax, ay, bx, by;

  // Shadow frame state
  int                  col_pos, row_pos;
  logic [SAMPLE_W-1:0] run_min, run_max;
  longint              run_sum;
  int                  run_count;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int grid_clamp(input logic [GRID_REG_W-1:0] g);
    if (g == 0) return 1;
    if (g > GRID_LIMIT) return GRID_LIMIT;
    return int'(g);
  endfunction

  // Clip one axis to the image and scale it to grid cells
  function automatic bit axis_span(input logic [CFG_W-1:0] ca, input logic [CFG_W-1:0] cb,
                                   input int img, input int grid,
                                   output int lo, output int hi);
    int a, b, l, r;
    a = int'($signed(ca));
    b = int'($signed(cb));
    l = (a < b) ? a : b;
    r = (a < b) ? b : a;
    lo = 0;
    hi = 0;
    if (l < 0) l = 0;
    if (r > img) r = img;
    if (r - l <= 0) return 1'b0;
    lo = l * grid / img;
    hi = r * grid / img;
    if (lo > grid - 1) lo = grid - 1;
    if (hi > grid - 1) hi = grid - 1;
    return 1'b1;
  endfunction

  task automatic clear_frame_state();
    col_pos   = 0;
    row_pos   = 0;
    run_min   = '1;
    run_max   = '0;
    run_sum   = 0;
    run_count = 0;
  endtask

  task automatic store_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    case (idx)
      REG_IMAGE_WIDTH:  img_w  = val[IMG_W-1:0];
      REG_IMAGE_HEIGHT: img_h  = val[IMG_W-1:0];
      REG_GRID_WIDTH:   grid_w = val[GRID_REG_W-1:0];
      REG_GRID_HEIGHT:  grid_h = val[GRID_REG_W-1:0];
      REG_CORNER_A_X:   ax     = val;
      REG_CORNER_A_Y:   ay     = val;
      REG_CORNER_B_X:   bx     = val;
      REG_CORNER_B_Y:   by     = val;
      default: ;
    endcase
  endtask

  // Fold one accepted sample into the frame statistics
  task automatic fold_sample(input logic [SAMPLE_W-1:0] s, input logic last);
    int          gw, gh, x0, x1, y0, y1;
    bit          region_ok;
    roi_result_t res;
    gw = grid_clamp(grid_w);
    gh = grid_clamp(grid_h);
    x0 = 0; x1 = 0; y0 = 0; y1 = 0;
    region_ok = 1'b0;
    if (img_w != 0 && img_h != 0) begin
      region_ok = axis_span(ax, bx, int'(img_w), gw, x0, x1);
      if (region_ok) region_ok = axis_span(ay, by, int'(img_h), gh, y0, y1);
    end
    if (region_ok && col_pos >= x0 && col_pos <= x1 && row_pos >= y0 && row_pos <= y1) begin
      if (s < run_min) run_min = s;
      if (s > run_max) run_max = s;
      // freeze sum and count together once the count saturates
      if (run_count < int'(COUNT_MAX)) begin
        run_sum += s;
        run_count++;
      end
    end
    // advance the raster position
    if (col_pos >= gw - 1) begin
      col_pos = 0;
      row_pos = (row_pos >= gh - 1) ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
    if (last) begin
      res = '0;
      res.region_valid = region_ok;
      if (region_ok && run_count > 0) begin
        res.min_sample  = run_min;
        res.max_sample  = run_max;
        res.mean_sample = SAMPLE_W'(run_sum / run_count);
        res.cell_count  = COUNT_W'(run_count);
      end
      frame_stats_due = {frame_stats_due, res};
      clear_frame_state();
    end
  endtask

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  task automatic check_result(input roi_result_t exp);
    roi_result_t got;
    got.region_valid = m_tuser;
    got.min_sample   = m_tdata[15:0];
    got.max_sample   = m_tdata[31:16];
    got.mean_sample  = m_tdata[47:32];
    got.cell_count   = m_tdata[68:48];
    if (got !== exp)
      note_failure($sformatf({"result mismatch: expected valid=%0d min=%0d max=%0d mean=%0d ",
                              "count=%0d, got valid=%0d min=%0d max=%0d mean=%0d count=%0d"},
                             exp.region_valid, exp.min_sample, exp.max_sample,
                             exp.mean_sample, exp.cell_count, got.region_valid,
                             got.min_sample, got.max_sample, got.mean_sample,
                             got.cell_count));
  endtask

  // ------------------------------------------------------- driver and monitor

  // Present queued beats; hold a beat until it is taken
  always @(posedge clk) begin : drive_samples
    sample_beat_t beat;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (sample_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        beat = sample_queue[0];
        sample_queue.delete(0);
        s_tvalid <= 1'b1;
        s_tdata  <= beat.sample;
        s_tlast  <= beat.last;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Count down a long receiver hold-off when one is asked for
  always @(posedge clk) begin
    if (rst) begin
      hold_left    <= 0;
      holds_served <= 0;
    end else if (holds_served != holds_asked) begin
      holds_served <= holds_asked;
      hold_left    <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Check result beats, then predict from accepted sample beats
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (frame_stats_due.size() == 0) begin
          note_failure("result beat with nothing expected");
        end else begin
          check_result(frame_stats_due[0]);
          frame_stats_due.delete(0);
        end
      end
      if (s_tvalid && s_tready) fold_sample(s_tdata, s_tlast);
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return SAMPLE_W'($urandom_range(2700, 3200));
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_image_dim();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return CFG_W'(4095);
      2:       return CFG_W'($urandom_range(0, 8191));
      default: return CFG_W'($urandom_range(1, 40));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_grid_dim();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CFG_W'(GRID_LIMIT);
      2:       return CFG_W'(2047);
      3:       return CFG_W'($urandom_range(0, 2047));
      default: return CFG_W'($urandom_range(1, 10));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_corner(input int img);
    case ($urandom_range(0, 9))
      0:       return 13'h1000;
      1:       return 13'h0FFF;
      2:       return CFG_W'($urandom_range(0, 8191));
      default: return CFG_W'(int'($urandom_range(0, img + 16)) - 8);
    endcase
  endfunction

  // Mostly whole frames over the grid, otherwise short or ragged ones
  function automatic int pick_frame_len();
    int cells;
    cells = grid_clamp(grid_w) * grid_clamp(grid_h);
    if (cells <= 120 && $urandom_range(0, 3) != 0) return cells;
    return $urandom_range(1, 40);
  endfunction

  task automatic push_item(input logic [SAMPLE_W-1:0] s, input logic last);
    sample_beat_t b;
    b.sample = s;
    b.last   = last;
    sample_queue = {sample_queue, b};
  endtask

  task automatic push_frame(input int len);
    for (int i = 0; i < len; i++) push_item(pick_sample(), i == len - 1);
  endtask

  // Each call launches one write; finish a series with end_writes
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    store_reg(idx, val);
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure_phase();
    logic [CFG_W-1:0] iw, ih;
    iw = pick_image_dim();
    ih = pick_image_dim();
    write_reg(REG_IMAGE_WIDTH, iw);
    write_reg(REG_IMAGE_HEIGHT, ih);
    write_reg(REG_GRID_WIDTH, pick_grid_dim());
    write_reg(REG_GRID_HEIGHT, pick_grid_dim());
    write_reg(REG_CORNER_A_X, pick_corner(int'(iw[IMG_W-1:0])));
    write_reg(REG_CORNER_A_Y, pick_corner(int'(ih[IMG_W-1:0])));
    write_reg(REG_CORNER_B_X, pick_corner(int'(iw[IMG_W-1:0])));
    write_reg(REG_CORNER_B_Y, pick_corner(int'(ih[IMG_W-1:0])));
    end_writes();
  endtask

  // Let every queued beat go in and every expected result come out
  task automatic wait_idle();
    while (sample_queue.size() != 0 || s_tvalid || frame_stats_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = REG_IMAGE_WIDTH;
    cfg_data      = '0;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tlast       = 1'b0;
    m_tready      = 1'b0;
    fail_count    = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    holds_asked   = 0;
    img_w  = IMG_W'(640);
    img_h  = IMG_W'(512);
    grid_w = GRID_REG_W'(256);
    grid_h = GRID_REG_W'(192);
    ax = '0; ay = '0; bx = '0; by = '0;
    clear_frame_state();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset registers: both corners at the origin, so the region is empty
    push_item('0, 1'b0);
    push_item('1, 1'b1);
    wait_idle();

    // Small grid with a 3x2 window; extremes inside it, then a frame that
    // ends before the window is reached
    write_reg(REG_IMAGE_WIDTH, 13'd8);
    write_reg(REG_IMAGE_HEIGHT, 13'd6);
    write_reg(REG_GRID_WIDTH, 13'd4);
    write_reg(REG_GRID_HEIGHT, 13'd3);
    write_reg(REG_CORNER_A_X, 13'd2);
    write_reg(REG_CORNER_A_Y, 13'd2);
    write_reg(REG_CORNER_B_X, 13'd6);
    write_reg(REG_CORNER_B_Y, 13'd4);
    end_writes();
    for (int i = 0; i < 12; i++)
      push_item((i == 6) ? 16'hFFFF : (i == 10) ? 16'h0000 : SAMPLE_W'(1000 + i * 37), i == 11);
    push_item(16'h1234, 1'b1);
    wait_idle();

    // Change the corners mid-frame: reversed order, partly off the image
    for (int i = 0; i < 3; i++) push_item(pick_sample(), 1'b0);
    wait_idle();
    write_reg(REG_CORNER_A_X, 13'd6);
    write_reg(REG_CORNER_A_Y, 13'd4);
    write_reg(REG_CORNER_B_X, -13'sd3);
    write_reg(REG_CORNER_B_Y, -13'sd2);
    end_writes();
    for (int i = 0; i < 4; i++) push_item(pick_sample(), i == 3);
    wait_idle();

    // Zero image width empties the region
    write_reg(REG_IMAGE_WIDTH, 13'd0);
    end_writes();
    push_item(16'h8000, 1'b1);
    wait_idle();

    // Grid sizes of zero and past the limit saturate; corners at the extremes
    write_reg(REG_IMAGE_WIDTH, 13'd4095);
    write_reg(REG_IMAGE_HEIGHT, 13'd1);
    write_reg(REG_GRID_WIDTH, 13'd0);
    write_reg(REG_GRID_HEIGHT, 13'd2047);
    write_reg(REG_CORNER_A_X, 13'h1000);
    write_reg(REG_CORNER_A_Y, 13'h0FFF);
    write_reg(REG_CORNER_B_X, 13'h0FFF);
    write_reg(REG_CORNER_B_Y, 13'h1000);
    end_writes();
    push_item(16'h7FFF, 1'b0);
    push_item(16'h0001, 1'b1);
    wait_idle();

    // Random phases: slow receiver, then slow sender, then full rate
    for (int p = 0; p < PHASES; p++) begin
      int made, len, tail;
      if (p < 5) begin
        send_idle_pct = 15;
        recv_idle_pct = 84;
      end else if (p < 10) begin
        send_idle_pct = 84;
        recv_idle_pct = 15;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      configure_phase();
      made = 0;
      if (p == PRESSURE_PHASE) begin
        // short frames against a stalled receiver fill the frame queue
        holds_asked++;
        while (made < PHASE_ITEMS) begin
          len = $urandom_range(1, 3);
          push_frame(len);
          made += len;
        end
      end else begin
        while (made < PHASE_ITEMS) begin
          len = pick_frame_len();
          push_frame(len);
          made += len;
        end
      end
      // sometimes leave a frame open across the next register change
      if ($urandom_range(0, 3) == 0) begin
        tail = $urandom_range(1, 5);
        for (int i = 0; i < tail; i++) push_item(pick_sample(), 1'b0);
      end
      wait_idle();
    end

    if (frame_stats_due.size() != 0) note_failure("expected results left over");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
